// ===== rtl/core/cdp_pkg.sv =====
`timescale 1ns / 1ps

package cdp_pkg;

  localparam int COMP_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 13;
  localparam int SIZE_BITS      = 14;
  localparam int CFG_IDX_BITS   = 8;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(512);

  localparam logic [CFG_IDX_BITS-1:0] CFG_FACE_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FACE_HEIGHT = CFG_IDX_BITS'(1);

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  // Per-item control that rides along the pipeline
  typedef struct packed {
    face_t face;
    logic  invalid;
  } cdp_tag_t;

endpackage

// ===== rtl/core/cdp_face_sel.sv =====
`timescale 1ns / 1ps

module cdp_face_sel import cdp_pkg::*; #(
  parameter int COMP_BITS = COMP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COMP_BITS-1:0] dir_x,
  input  logic [COMP_BITS-1:0] dir_y,
  input  logic [COMP_BITS-1:0] dir_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cdp_tag_t             out_tag,
  output logic [COMP_BITS-1:0] out_den,
  output logic [COMP_BITS:0]   out_row_n,
  output logic [COMP_BITS:0]   out_col_n
);

  localparam int CB = COMP_BITS;

  logic [CB-1:0] ax, ay, az;
  logic          pick_x, pick_y;
  face_t         face_sel;
  logic [CB-1:0] den_sel;
  logic [CB-1:0] col_comp, row_comp;
  logic          col_sub, row_sub;
  logic [CB+1:0] den_e, col_e, row_e, col_sum, row_sum;
  logic          adv;

  // Magnitudes; the most negative value maps to 2^(CB-1) exactly
  assign ax = dir_x[CB-1] ? (~dir_x + CB'(1)) : dir_x;
  assign ay = dir_y[CB-1] ? (~dir_y + CB'(1)) : dir_y;
  assign az = dir_z[CB-1] ? (~dir_z + CB'(1)) : dir_z;

  assign pick_x = (ax >= ay) && (ax >= az);
  assign pick_y = (ay >= az);

  // col = den +/- s-component, row = den -/+ t-component
  always_comb begin
    if (pick_x) begin
      den_sel  = ax;
      row_comp = dir_y;
      row_sub  = 1'b1;
      col_comp = dir_z;
      if (!dir_x[CB-1]) begin
        face_sel = FACE_POS_X;
        col_sub  = 1'b1;
      end else begin
        face_sel = FACE_NEG_X;
        col_sub  = 1'b0;
      end
    end else if (pick_y) begin
      den_sel  = ay;
      col_comp = dir_x;
      col_sub  = 1'b0;
      row_comp = dir_z;
      if (!dir_y[CB-1]) begin
        face_sel = FACE_POS_Y;
        row_sub  = 1'b0;
      end else begin
        face_sel = FACE_NEG_Y;
        row_sub  = 1'b1;
      end
    end else begin
      den_sel  = az;
      col_comp = dir_x;
      row_comp = dir_y;
      row_sub  = 1'b1;
      if (!dir_z[CB-1]) begin
        face_sel = FACE_POS_Z;
        col_sub  = 1'b0;
      end else begin
        face_sel = FACE_NEG_Z;
        col_sub  = 1'b1;
      end
    end
  end

  assign den_e   = {2'b00, den_sel};
  assign col_e   = {{2{col_comp[CB-1]}}, col_comp};
  assign row_e   = {{2{row_comp[CB-1]}}, row_comp};
  assign col_sum = col_sub ? (den_e - col_e) : (den_e + col_e);
  assign row_sum = row_sub ? (den_e - row_e) : (den_e + row_e);

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_tag.face    <= face_sel;
      out_tag.invalid <= (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
      out_den         <= den_sel;
      out_row_n       <= row_sum[CB:0];
      out_col_n       <= col_sum[CB:0];
    end
  end

endmodule

// ===== rtl/core/cdp_scale_mul.sv =====
`timescale 1ns / 1ps

module cdp_scale_mul import cdp_pkg::*; #(
  parameter int COMP_BITS = COMP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [SIZE_BITS-1:0]           face_width,
  input  logic [SIZE_BITS-1:0]           face_height,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cdp_tag_t                       in_tag,
  input  logic [COMP_BITS-1:0]           in_den,
  input  logic [COMP_BITS:0]             in_row_n,
  input  logic [COMP_BITS:0]             in_col_n,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cdp_tag_t                       out_tag,
  output logic [COMP_BITS-1:0]           out_den,
  output logic [COMP_BITS+SIZE_BITS:0]   out_row_p,
  output logic [COMP_BITS+SIZE_BITS:0]   out_col_p
);

  localparam int NB = COMP_BITS + 1;
  localparam int PB = COMP_BITS + SIZE_BITS + 1;

  logic [SIZE_BITS-1:0] w_scale, h_scale;
  logic [PB-1:0]        row_p, col_p;
  logic                 adv;

  // Scale is size - 1, with sizes 0 and 1 both giving 0
  assign w_scale = (face_width  == '0) ? '0 : face_width  - SIZE_BITS'(1);
  assign h_scale = (face_height == '0) ? '0 : face_height - SIZE_BITS'(1);

  assign row_p = {{(PB-NB){1'b0}}, in_row_n} * {{(PB-SIZE_BITS){1'b0}}, h_scale};
  assign col_p = {{(PB-NB){1'b0}}, in_col_n} * {{(PB-SIZE_BITS){1'b0}}, w_scale};

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_tag   <= in_tag;
      out_den   <= in_den;
      out_row_p <= row_p;
      out_col_p <= col_p;
    end
  end

endmodule

// ===== rtl/core/cdp_div_pipe.sv =====
`timescale 1ns / 1ps

module cdp_div_pipe import cdp_pkg::*; #(
  parameter int COMP_BITS = COMP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cdp_tag_t                       in_tag,
  input  logic [COMP_BITS-1:0]           in_den,
  input  logic [COMP_BITS+SIZE_BITS:0]   in_row_p,
  input  logic [COMP_BITS+SIZE_BITS:0]   in_col_p,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cdp_tag_t                       out_tag,
  output logic [SIZE_BITS-1:0]           out_row_q,
  output logic [SIZE_BITS-1:0]           out_col_q
);

  localparam int QB = SIZE_BITS;
  localparam int DB = COMP_BITS + 1;
  localparam int PB = COMP_BITS + SIZE_BITS + 1;

  logic [PB-1:0] rem_row [QB];
  logic [PB-1:0] rem_col [QB];
  logic [QB-1:0] quo_row [QB];
  logic [QB-1:0] quo_col [QB];
  logic [DB-1:0] dvs     [QB];
  cdp_tag_t      tag     [QB];
  logic [QB-1:0] vld;
  logic [QB:0]   adv;

  assign adv[QB]   = out_ready;
  assign in_ready  = adv[0];
  assign out_valid = vld[QB-1];
  assign out_tag   = tag[QB-1];
  assign out_row_q = quo_row[QB-1];
  assign out_col_q = quo_col[QB-1];

  // One quotient bit per stage, most significant first. The product is
  // below divisor * 2^QB, so the remainder always fits the next trial.
  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;

    logic [PB-1:0] r_row_in, r_col_in, trial;
    logic [QB-1:0] q_row_in, q_col_in;
    logic [DB-1:0] d_in;
    cdp_tag_t      t_in;
    logic          v_in;
    logic [PB-1:0] r_row_next, r_col_next;
    logic [QB-1:0] q_row_next, q_col_next;

    if (k == 0) begin : g_first
      assign r_row_in = in_row_p;
      assign r_col_in = in_col_p;
      assign q_row_in = '0;
      assign q_col_in = '0;
      assign d_in     = {in_den, 1'b0};
      assign t_in     = in_tag;
      assign v_in     = in_valid;
    end else begin : g_rest
      assign r_row_in = rem_row[k-1];
      assign r_col_in = rem_col[k-1];
      assign q_row_in = quo_row[k-1];
      assign q_col_in = quo_col[k-1];
      assign d_in     = dvs[k-1];
      assign t_in     = tag[k-1];
      assign v_in     = vld[k-1];
    end

    assign trial = {{(PB-DB){1'b0}}, d_in} << SH;

    always_comb begin
      r_row_next = r_row_in;
      q_row_next = q_row_in;
      r_col_next = r_col_in;
      q_col_next = q_col_in;
      if (r_row_in >= trial) begin
        r_row_next = r_row_in - trial;
        q_row_next = q_row_in | (QB'(1) << SH);
      end
      if (r_col_in >= trial) begin
        r_col_next = r_col_in - trial;
        q_col_next = q_col_in | (QB'(1) << SH);
      end
    end

    // Advance when empty or when the next stage takes the item
    assign adv[k] = !vld[k] || adv[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && v_in) begin
        rem_row[k] <= r_row_next;
        rem_col[k] <= r_col_next;
        quo_row[k] <= q_row_next;
        quo_col[k] <= q_col_next;
        dvs[k]     <= d_in;
        tag[k]     <= t_in;
      end
    end
  end

endmodule

// ===== rtl/core/cubemap_dir_to_pixel_top.sv =====
`timescale 1ns / 1ps

// Cube map face select and texel addressing. Each transfer on the slave
// stream carries one direction (three signed components); one transfer on
// the master stream answers it with the face (0 +x, 1 -x, 2 +y, 3 -y, 4 +z,
// 5 -z, ties going to x, then y), the pixel row and column on that face,
// and an invalid flag for the zero vector (face 0, row 0, column 0). The
// coordinates are exact floors of (n + den) * (size - 1) / (2 * den), so
// no rounding is introduced; values above the coordinate range saturate.
// One direction is taken per clock, sustained while the master takes
// results. Each goes through face select, scale multiply, a 14-stage
// restoring divider with one quotient bit per stage, and the output
// register. The divider stages set the depth. Stages fill bubbles
// independently, so a stalled master still lets the pipe soak up new
// directions until every stage is full. Face sizes come from the
// configuration channel (index 0 width, index 1 height, both reset to 512)
// and must only change while the pipe is empty.
module cubemap_dir_to_pixel_top import cdp_pkg::*; #(
  parameter int COMP_BITS  = COMP_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // dir_x, dir_y, dir_z from bit 0 up, zero padded to whole bytes
  input  logic [((3*COMP_BITS+7)/8)*8-1:0]      s_tdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // face_index, pixel_row, pixel_col from bit 0 up, zero padded
  output logic [((3+2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
  // invalid_dir
  output logic                                  m_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]               cfg_index,
  input  logic [SIZE_BITS-1:0]                  cfg_data
);

  localparam int OUT_W = ((3 + 2*COORD_BITS + 7) / 8) * 8;
  localparam logic [31:0] COORD_MAX = 32'((64'd1 << COORD_BITS) - 64'd1);

  logic [SIZE_BITS-1:0] face_width, face_height;

  // Stage 1 -> stage 2
  logic                 fs_valid, fs_ready;
  cdp_tag_t             fs_tag;
  logic [COMP_BITS-1:0] fs_den;
  logic [COMP_BITS:0]   fs_row_n, fs_col_n;

  // Stage 2 -> divider
  logic                           ml_valid, ml_ready;
  cdp_tag_t                       ml_tag;
  logic [COMP_BITS-1:0]           ml_den;
  logic [COMP_BITS+SIZE_BITS:0]   ml_row_p, ml_col_p;

  // Divider -> output register
  logic                 dv_valid, dv_ready;
  cdp_tag_t             dv_tag;
  logic [SIZE_BITS-1:0] dv_row_q, dv_col_q;

  logic [COORD_BITS-1:0] row_sat, col_sat;
  logic [COORD_BITS-1:0] pixel_row, pixel_col;
  face_t                 face_index;
  logic                  out_adv;

  // Configuration: always ready, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_width  <= SIZE_RESET;
      face_height <= SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FACE_WIDTH:  face_width  <= cfg_data;
        CFG_FACE_HEIGHT: face_height <= cfg_data;
        default: ;
      endcase
    end
  end

  cdp_face_sel #(
    .COMP_BITS (COMP_BITS)
  ) u_face_sel (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .dir_x     (s_tdata[COMP_BITS-1:0]),
    .dir_y     (s_tdata[2*COMP_BITS-1:COMP_BITS]),
    .dir_z     (s_tdata[3*COMP_BITS-1:2*COMP_BITS]),
    .out_valid (fs_valid),
    .out_ready (fs_ready),
    .out_tag   (fs_tag),
    .out_den   (fs_den),
    .out_row_n (fs_row_n),
    .out_col_n (fs_col_n)
  );

  cdp_scale_mul #(
    .COMP_BITS (COMP_BITS)
  ) u_scale_mul (
    .clk         (clk),
    .rst         (rst),
    .face_width  (face_width),
    .face_height (face_height),
    .in_valid    (fs_valid),
    .in_ready    (fs_ready),
    .in_tag      (fs_tag),
    .in_den      (fs_den),
    .in_row_n    (fs_row_n),
    .in_col_n    (fs_col_n),
    .out_valid   (ml_valid),
    .out_ready   (ml_ready),
    .out_tag     (ml_tag),
    .out_den     (ml_den),
    .out_row_p   (ml_row_p),
    .out_col_p   (ml_col_p)
  );

  cdp_div_pipe #(
    .COMP_BITS (COMP_BITS)
  ) u_div_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ml_valid),
    .in_ready  (ml_ready),
    .in_tag    (ml_tag),
    .in_den    (ml_den),
    .in_row_p  (ml_row_p),
    .in_col_p  (ml_col_p),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_tag   (dv_tag),
    .out_row_q (dv_row_q),
    .out_col_q (dv_col_q)
  );

  // Saturate to the coordinate range; zero vector forces the coordinates to 0
  always_comb begin
    row_sat = ({{(32-SIZE_BITS){1'b0}}, dv_row_q} > COORD_MAX) ?
              COORD_MAX[COORD_BITS-1:0] : COORD_BITS'(dv_row_q);
    col_sat = ({{(32-SIZE_BITS){1'b0}}, dv_col_q} > COORD_MAX) ?
              COORD_MAX[COORD_BITS-1:0] : COORD_BITS'(dv_col_q);
    if (dv_tag.invalid) begin
      row_sat = '0;
      col_sat = '0;
    end
  end

  // Output register: load when empty or when the current result is taken
  assign out_adv  = !m_tvalid || m_tready;
  assign dv_ready = out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && dv_valid) begin
      face_index <= dv_tag.face;
      pixel_row  <= row_sat;
      pixel_col  <= col_sat;
      m_tuser    <= dv_tag.invalid;
    end
  end

  assign m_tdata = OUT_W'({pixel_col, pixel_row, face_index});

  // A ready master never backs up the pipe
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output side is ready");

  // Zero vector result is face 0 at the origin
  a_invalid_origin: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (face_index == FACE_POS_X) && (pixel_row == '0) && (pixel_col == '0))
    else $error("invalid direction with nonzero face or coordinates");

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // The divider never hands over a quotient above the largest scale
  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    (dv_valid && !dv_tag.invalid) |->
      (dv_row_q != '1) && (dv_col_q != '1))
    else $error("quotient out of range");

endmodule
